>>> src/dbms_pkg.sv
// Package for the backplane DMA bus master sequencer.
// Holds field widths, reset constants, register indexes and the structs that
// pass between the top level and the sequencer core. Depends on nothing.
package dbms_pkg;

    localparam int BUS_W   = 24;
    localparam int WORD_W  = 16;
    localparam int GAP_W   = 8;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [BUS_W-1:0]   BUS_RELEASED  = 24'hFF_FFFF;
    localparam logic [GAP_W-1:0]   GAP_RESET     = 8'd32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd1;

    typedef struct packed {
        logic              start_request;
        logic [BUS_W-1:0]  start_address;
        logic              start_is_write;
        logic [WORD_W-1:0] start_write_data;
        logic              ack_taken;
        logic              mem_cycle_n;
        logic              grant_in_n;
        logic              io_cycle_n;
        logic              ready_n;
        logic [BUS_W-1:0]  bus_data_n;
    } t_item;

    typedef struct packed {
        logic [GAP_W-1:0]   recovery_gap;
        logic [LIMIT_W-1:0] timeout_limit;
    } t_cfg;

    typedef struct packed {
        logic              request_n;
        logic              address_strobe_n;
        logic              data_strobe_n;
        logic              direction_n;
        logic [BUS_W-1:0]  bus_drive_n;
        logic              start_accepted;
        logic              ack_valid;
        logic [WORD_W-1:0] ack_read_data;
        logic              ack_error;
        logic              busy_res;
        logic              collision;
    } t_result;

endpackage

>>> src/dbms_core.sv
// Sequencer core: bus tick, transfer phases, timeout and client acknowledge.
// All state advances by one bus clock per step. Depends on dbms_pkg.
module dbms_core #(
    parameter int ADDRESS_WIDTH = 24,
    parameter int DATA_WIDTH    = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  dbms_pkg::t_item  i_item,
    input  dbms_pkg::t_cfg   i_cfg,
    output dbms_pkg::t_result o_res
);

    localparam logic [63:0] ADDR_MASK64 = (64'd1 << ADDRESS_WIDTH) - 64'd1;
    localparam logic [63:0] DATA_MASK64 = (64'd1 << DATA_WIDTH) - 64'd1;
    localparam logic [dbms_pkg::BUS_W-1:0] ADDR_MASK = ADDR_MASK64[dbms_pkg::BUS_W-1:0];
    localparam logic [dbms_pkg::BUS_W-1:0] DATA_MASK = DATA_MASK64[dbms_pkg::BUS_W-1:0];

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REQ,
        PH_ADDR,
        PH_DATA,
        PH_END
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic                            r_is_write, n_is_write;
    logic [dbms_pkg::BUS_W-1:0]      r_held_address, n_held_address;
    logic [dbms_pkg::WORD_W-1:0]     r_held_write_data, n_held_write_data;
    logic [dbms_pkg::WORD_W-1:0]     r_read_latch, n_read_latch;
    logic                            r_read_latched, n_read_latched;
    logic                            r_ack_pending, n_ack_pending;
    logic [dbms_pkg::WORD_W-1:0]     r_ack_data, n_ack_data;
    logic                            r_ack_err, n_ack_err;
    logic [dbms_pkg::GAP_W-1:0]      r_gap_count, n_gap_count;
    logic [1:0]                      r_phase_count, n_phase_count;
    logic [dbms_pkg::LIMIT_W-1:0]    r_busy_ticks, n_busy_ticks;
    logic                            r_prev_mem_n, n_prev_mem_n;
    logic                            r_frozen, n_frozen;
    logic                            r_req_n, n_req_n;
    logic                            r_apr_n, n_apr_n;
    logic                            r_dap_n, n_dap_n;
    logic                            r_dir_n, n_dir_n;
    logic [dbms_pkg::BUS_W-1:0]      r_bus_n, n_bus_n;

    always_comb begin
        logic                         fall;
        logic                         claim_ok;
        logic                         abort;
        logic                         accepted;
        logic                         av;
        logic [dbms_pkg::BUS_W-1:0]   read_word;

        n_phase           = r_phase;
        n_is_write        = r_is_write;
        n_held_address    = r_held_address;
        n_held_write_data = r_held_write_data;
        n_read_latch      = r_read_latch;
        n_read_latched    = r_read_latched;
        n_ack_pending     = r_ack_pending;
        n_ack_data        = r_ack_data;
        n_ack_err         = r_ack_err;
        n_phase_count     = r_phase_count;
        n_busy_ticks      = r_busy_ticks;
        n_req_n           = r_req_n;
        n_apr_n           = r_apr_n;
        n_dap_n           = r_dap_n;
        n_dir_n           = r_dir_n;
        n_bus_n           = r_bus_n;
        n_prev_mem_n      = i_item.mem_cycle_n;
        accepted          = 1'b0;
        read_word         = ~i_item.bus_data_n & DATA_MASK;

        n_gap_count = (r_gap_count != '0) ? r_gap_count - 1'b1 : r_gap_count;

        // The freeze latch records that our request was already up when the
        // memory strobe fell, so a grant seen now belongs to this master.
        fall = !i_item.mem_cycle_n && r_prev_mem_n;
        n_frozen = r_frozen;
        if (i_item.mem_cycle_n) begin
            n_frozen = 1'b0;
        end else if (fall) begin
            n_frozen = (r_phase == PH_REQ) && !r_req_n;
        end
        claim_ok = n_frozen || (fall && (r_phase == PH_REQ) && !r_req_n);

        abort = !i_item.io_cycle_n && ((r_phase == PH_ADDR) || (r_phase == PH_DATA));

        if (abort) begin
            n_req_n     = 1'b1;
            n_apr_n     = 1'b1;
            n_dap_n     = 1'b1;
            n_dir_n     = 1'b1;
            n_bus_n     = dbms_pkg::BUS_RELEASED;
            n_frozen    = 1'b0;
            n_gap_count = i_cfg.recovery_gap;
            n_phase     = PH_REQ;
        end else begin
            case (r_phase)
                PH_REQ: begin
                    if (n_req_n && (n_gap_count == '0)) begin
                        n_req_n = 1'b0;
                    end
                    if (!i_item.mem_cycle_n && !i_item.grant_in_n && !n_req_n &&
                        claim_ok && i_item.io_cycle_n) begin
                        n_req_n       = 1'b1;
                        n_bus_n       = ~r_held_address;
                        n_apr_n       = 1'b0;
                        n_dir_n       = !r_is_write;
                        n_phase_count = 2'd2;
                        n_phase       = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (r_phase_count != 2'd0) begin
                        n_phase_count = r_phase_count - 2'd1;
                    end else begin
                        n_apr_n        = 1'b1;
                        n_dir_n        = 1'b1;
                        n_bus_n        = r_is_write ?
                            ~{{(dbms_pkg::BUS_W-dbms_pkg::WORD_W){1'b0}}, r_held_write_data} :
                            dbms_pkg::BUS_RELEASED;
                        n_dap_n        = 1'b0;
                        n_read_latched = 1'b0;
                        n_phase        = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (!r_is_write && (i_item.bus_data_n != dbms_pkg::BUS_RELEASED)) begin
                        n_read_latch   = read_word[dbms_pkg::WORD_W-1:0];
                        n_read_latched = 1'b1;
                    end
                    if (!i_item.ready_n) begin
                        if (!r_is_write) begin
                            n_ack_data = n_read_latched ? n_read_latch :
                                                          read_word[dbms_pkg::WORD_W-1:0];
                        end
                        n_dap_n = 1'b1;
                        n_bus_n = dbms_pkg::BUS_RELEASED;
                        n_dir_n = 1'b1;
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    if (i_item.ready_n) begin
                        n_ack_pending = 1'b1;
                        n_ack_err     = 1'b0;
                        n_gap_count   = i_cfg.recovery_gap;
                        n_phase       = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase

            if (n_phase != PH_IDLE) begin
                n_busy_ticks = r_busy_ticks + 1'b1;
                if (n_busy_ticks >= i_cfg.timeout_limit) begin
                    n_req_n       = 1'b1;
                    n_apr_n       = 1'b1;
                    n_dap_n       = 1'b1;
                    n_dir_n       = 1'b1;
                    n_bus_n       = dbms_pkg::BUS_RELEASED;
                    n_ack_pending = 1'b1;
                    n_ack_err     = 1'b1;
                    n_ack_data    = '0;
                    n_gap_count   = i_cfg.recovery_gap;
                    n_phase       = PH_IDLE;
                end
            end else begin
                n_busy_ticks = '0;
            end
        end

        // The acknowledge shown is the one pending after the tick.
        av = n_ack_pending;
        o_res.ack_valid     = av;
        o_res.ack_read_data = av ? n_ack_data : '0;
        o_res.ack_error     = av && n_ack_err;
        if (i_item.ack_taken) begin
            n_ack_pending = 1'b0;
        end

        if (i_item.start_request && (n_phase == PH_IDLE) && !n_ack_pending) begin
            n_is_write        = i_item.start_is_write;
            n_held_address    = i_item.start_address & ADDR_MASK;
            n_held_write_data = i_item.start_write_data & DATA_MASK[dbms_pkg::WORD_W-1:0];
            n_busy_ticks      = '0;
            n_phase           = PH_REQ;
            accepted          = 1'b1;
        end

        o_res.request_n        = n_req_n;
        o_res.address_strobe_n = n_apr_n;
        o_res.data_strobe_n    = n_dap_n;
        o_res.direction_n      = n_dir_n;
        o_res.bus_drive_n      = n_bus_n;
        o_res.start_accepted   = accepted;
        o_res.busy_res         = (n_phase != PH_IDLE) || n_ack_pending;
        o_res.collision        = !i_item.io_cycle_n &&
            ((r_phase == PH_ADDR) || (r_phase == PH_DATA) || (r_phase == PH_END));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_is_write        <= 1'b0;
            r_held_address    <= '0;
            r_held_write_data <= '0;
            r_read_latch      <= '0;
            r_read_latched    <= 1'b0;
            r_ack_pending     <= 1'b0;
            r_ack_data        <= '0;
            r_ack_err         <= 1'b0;
            r_gap_count       <= '0;
            r_phase_count     <= '0;
            r_busy_ticks      <= '0;
            r_prev_mem_n      <= 1'b1;
            r_frozen          <= 1'b0;
            r_req_n           <= 1'b1;
            r_apr_n           <= 1'b1;
            r_dap_n           <= 1'b1;
            r_dir_n           <= 1'b1;
            r_bus_n           <= dbms_pkg::BUS_RELEASED;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_is_write        <= n_is_write;
            r_held_address    <= n_held_address;
            r_held_write_data <= n_held_write_data;
            r_read_latch      <= n_read_latch;
            r_read_latched    <= n_read_latched;
            r_ack_pending     <= n_ack_pending;
            r_ack_data        <= n_ack_data;
            r_ack_err         <= n_ack_err;
            r_gap_count       <= n_gap_count;
            r_phase_count     <= n_phase_count;
            r_busy_ticks      <= n_busy_ticks;
            r_prev_mem_n      <= n_prev_mem_n;
            r_frozen          <= n_frozen;
            r_req_n           <= n_req_n;
            r_apr_n           <= n_apr_n;
            r_dap_n           <= n_dap_n;
            r_dir_n           <= n_dir_n;
            r_bus_n           <= n_bus_n;
        end
    end

    a_addr_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ADDR) |-> !r_apr_n)
        else $error("address strobe released during address phase");

    a_data_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (!r_dap_n && r_apr_n))
        else $error("strobes wrong during data phase");

    a_quiet_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_IDLE) || (r_phase == PH_REQ)) |->
            (r_apr_n && r_dap_n && (r_bus_n == dbms_pkg::BUS_RELEASED)))
        else $error("bus driven outside a claimed cycle");

    a_start_enters_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.start_accepted) |=> (r_phase == PH_REQ))
        else $error("accepted start did not enter request phase");

endmodule

>>> src/dma_bus_master_sequencer_top.sv
// Top level of the backplane DMA bus master sequencer.
// Holds the configuration registers, the input handshake and the result
// register; instantiates dbms_core. Depends on dbms_pkg.

// Each input item is one bus clock of sampled lines and client requests; it
// yields exactly one result item, registered, in the cycle after acceptance.
// The block takes one item per clock: all work for an item is done in the
// core's next-state logic, and o_stall rises only while a finished result is
// waiting and the output side stalls. Configuration writes through i_cfg_we
// take effect at once and are meant for idle times.
module dma_bus_master_sequencer_top #(
    parameter int ADDRESS_WIDTH = 24,
    parameter int DATA_WIDTH    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_we,
    input  logic [dbms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbms_pkg::LIMIT_W-1:0]        i_cfg_data,

    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_start_request,
    input  logic [dbms_pkg::BUS_W-1:0]          i_start_address,
    input  logic                                i_start_is_write,
    input  logic [dbms_pkg::WORD_W-1:0]         i_start_write_data,
    input  logic                                i_ack_taken,
    input  logic                                i_mem_cycle_n,
    input  logic                                i_grant_in_n,
    input  logic                                i_io_cycle_n,
    input  logic                                i_ready_n,
    input  logic [dbms_pkg::BUS_W-1:0]          i_bus_data_n,

    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_request_n,
    output logic                                o_address_strobe_n,
    output logic                                o_data_strobe_n,
    output logic                                o_direction_n,
    output logic [dbms_pkg::BUS_W-1:0]          o_bus_drive_n,
    output logic                                o_start_accepted,
    output logic                                o_ack_valid,
    output logic [dbms_pkg::WORD_W-1:0]         o_ack_read_data,
    output logic                                o_ack_error,
    output logic                                o_busy_res,
    output logic                                o_collision
);

    logic [dbms_pkg::GAP_W-1:0]   r_recovery_gap;
    logic [dbms_pkg::LIMIT_W-1:0] r_timeout_limit;
    logic                         r_out_valid, n_out_valid;
    dbms_pkg::t_result            r_res;

    dbms_pkg::t_item   w_item;
    dbms_pkg::t_cfg    w_cfg;
    dbms_pkg::t_result w_res;
    logic              w_accept;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_item.start_request    = i_start_request;
    assign w_item.start_address    = i_start_address;
    assign w_item.start_is_write   = i_start_is_write;
    assign w_item.start_write_data = i_start_write_data;
    assign w_item.ack_taken        = i_ack_taken;
    assign w_item.mem_cycle_n      = i_mem_cycle_n;
    assign w_item.grant_in_n       = i_grant_in_n;
    assign w_item.io_cycle_n       = i_io_cycle_n;
    assign w_item.ready_n          = i_ready_n;
    assign w_item.bus_data_n       = i_bus_data_n;

    assign w_cfg.recovery_gap  = r_recovery_gap;
    assign w_cfg.timeout_limit = r_timeout_limit;

    dbms_core #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recovery_gap  <= dbms_pkg::GAP_RESET;
            r_timeout_limit <= dbms_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dbms_pkg::CFG_RECOVERY_GAP) begin
                r_recovery_gap <= i_cfg_data[dbms_pkg::GAP_W-1:0];
            end else if (i_cfg_index == dbms_pkg::CFG_TIMEOUT_LIMIT) begin
                r_timeout_limit <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // The result payload holds while stalled because no item is accepted then.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_request_n        = r_res.request_n;
    assign o_address_strobe_n = r_res.address_strobe_n;
    assign o_data_strobe_n    = r_res.data_strobe_n;
    assign o_direction_n      = r_res.direction_n;
    assign o_bus_drive_n      = r_res.bus_drive_n;
    assign o_start_accepted   = r_res.start_accepted;
    assign o_ack_valid        = r_res.ack_valid;
    assign o_ack_read_data    = r_res.ack_read_data;
    assign o_ack_error        = r_res.ack_error;
    assign o_busy_res         = r_res.busy_res;
    assign o_collision        = r_res.collision;

endmodule

>>> verif/tb_dma_bus_master_sequencer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dma_bus_master_sequencer_top: scripted bus
// transfers followed by random bus clocks, checked against an in-bench model of
// the DMA master. Depends on dbms_pkg and the RTL of the block.
module tb_dma_bus_master_sequencer_top;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SCRIPT_LEN    = 25;
    localparam int N_SETTINGS    = 6;

    localparam logic [dbms_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [dbms_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam dbms_pkg::t_result RESULT_AT_REST = '{request_n: 1'b1,
        address_strobe_n: 1'b1, data_strobe_n: 1'b1, direction_n: 1'b1,
        bus_drive_n: dbms_pkg::BUS_RELEASED, default: '0};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REQUEST,
        PH_ADDRESS,
        PH_DATA,
        PH_END
    } t_bus_phase;

    typedef struct {
        dbms_pkg::t_item   stim;
        bit                typed;
        dbms_pkg::t_result res;
    } t_script_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [dbms_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [dbms_pkg::LIMIT_W-1:0]        i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic                                i_start_request = 1'b0;
    logic [dbms_pkg::BUS_W-1:0]          i_start_address = '0;
    logic                                i_start_is_write = 1'b0;
    logic [dbms_pkg::WORD_W-1:0]         i_start_write_data = '0;
    logic                                i_ack_taken = 1'b0;
    logic                                i_mem_cycle_n = 1'b1;
    logic                                i_grant_in_n = 1'b1;
    logic                                i_io_cycle_n = 1'b1;
    logic                                i_ready_n = 1'b1;
    logic [dbms_pkg::BUS_W-1:0]          i_bus_data_n = dbms_pkg::BUS_RELEASED;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic                                o_request_n;
    logic                                o_address_strobe_n;
    logic                                o_data_strobe_n;
    logic                                o_direction_n;
    logic [dbms_pkg::BUS_W-1:0]          o_bus_drive_n;
    logic                                o_start_accepted;
    logic                                o_ack_valid;
    logic [dbms_pkg::WORD_W-1:0]         o_ack_read_data;
    logic                                o_ack_error;
    logic                                o_busy_res;
    logic                                o_collision;

    dma_bus_master_sequencer_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_start_request    (i_start_request),
        .i_start_address    (i_start_address),
        .i_start_is_write   (i_start_is_write),
        .i_start_write_data (i_start_write_data),
        .i_ack_taken        (i_ack_taken),
        .i_mem_cycle_n      (i_mem_cycle_n),
        .i_grant_in_n       (i_grant_in_n),
        .i_io_cycle_n       (i_io_cycle_n),
        .i_ready_n          (i_ready_n),
        .i_bus_data_n       (i_bus_data_n),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_request_n        (o_request_n),
        .o_address_strobe_n (o_address_strobe_n),
        .o_data_strobe_n    (o_data_strobe_n),
        .o_direction_n      (o_direction_n),
        .o_bus_drive_n      (o_bus_drive_n),
        .o_start_accepted   (o_start_accepted),
        .o_ack_valid        (o_ack_valid),
        .o_ack_read_data    (o_ack_read_data),
        .o_ack_error        (o_ack_error),
        .o_busy_res         (o_busy_res),
        .o_collision        (o_collision)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Model of the master: registers, transfer state and the lines it drives.
    logic [dbms_pkg::GAP_W-1:0]   cfg_gap = dbms_pkg::GAP_RESET;
    logic [dbms_pkg::LIMIT_W-1:0] cfg_limit = dbms_pkg::LIMIT_RESET;
    t_bus_phase                   bus_phase = PH_IDLE;
    logic                         xfer_is_write = 1'b0;
    logic [dbms_pkg::BUS_W-1:0]   xfer_address = '0;
    logic [dbms_pkg::WORD_W-1:0]  xfer_wdata = '0;
    logic [dbms_pkg::WORD_W-1:0]  rd_latch = '0;
    logic                         rd_latched = 1'b0;
    logic                         ack_pend = 1'b0;
    logic [dbms_pkg::WORD_W-1:0]  ack_word = '0;
    logic                         ack_is_err = 1'b0;
    logic [dbms_pkg::GAP_W-1:0]   gap_left = '0;
    logic [1:0]                   addr_hold = '0;
    logic [dbms_pkg::LIMIT_W-1:0] busy_ticks = '0;
    logic                         last_mem_n = 1'b1;
    logic                         req_frozen = 1'b0;
    logic                         drv_req_n = 1'b1;
    logic                         drv_astb_n = 1'b1;
    logic                         drv_dstb_n = 1'b1;
    logic                         drv_dir_n = 1'b1;
    logic [dbms_pkg::BUS_W-1:0]   drv_bus_n = dbms_pkg::BUS_RELEASED;

    dbms_pkg::t_result bus_results_due[$];
    t_script_row       script[SCRIPT_LEN];
    logic              mem_line = 1'b1;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned n_checked = 0;
    int unsigned n_started = 0;
    int unsigned n_acked = 0;
    int unsigned n_timeouts = 0;
    int unsigned n_aborts = 0;
    int unsigned n_collisions = 0;
    int unsigned cycle_count = 0;

    int unsigned gap_plan[N_SETTINGS]   = '{0, 3, 255, 5, 2, 32};
    int unsigned limit_plan[N_SETTINGS] = '{65535, 0, 300, 12, 1, 4096};
    int unsigned count_plan[N_SETTINGS] = '{300, 60, 150, 250, 40, 350};
    int unsigned mode_plan[N_SETTINGS]  = '{0, 0, 1, 1, 2, 2};

    function automatic dbms_pkg::t_item bus_item(bit st, logic [dbms_pkg::BUS_W-1:0] ad,
                                                 bit wr, logic [dbms_pkg::WORD_W-1:0] wd,
                                                 bit tk, bit mem, bit gnt, bit io, bit rdy,
                                                 logic [dbms_pkg::BUS_W-1:0] bus);
        dbms_pkg::t_item it;
        it = '{st, ad, wr, wd, tk, mem, gnt, io, rdy, bus};
        return it;
    endfunction

    task automatic release_lines();
        drv_req_n  = 1'b1;
        drv_astb_n = 1'b1;
        drv_dstb_n = 1'b1;
        drv_dir_n  = 1'b1;
        drv_bus_n  = dbms_pkg::BUS_RELEASED;
    endtask

    // One bus clock: the bus tick first, then the client side.
    task automatic step_bus_master(input dbms_pkg::t_item it, output dbms_pkg::t_result r);
        logic req_low;
        logic fall;
        logic frozen_now;
        r = '0;
        r.collision = !it.io_cycle_n &&
                      (bus_phase == PH_ADDRESS || bus_phase == PH_DATA || bus_phase == PH_END);
        if (r.collision) n_collisions++;

        if (gap_left != 0) gap_left--;
        req_low = !drv_req_n;
        fall = !it.mem_cycle_n && last_mem_n;
        if (it.mem_cycle_n) req_frozen = 1'b0;
        else if (fall) req_frozen = (bus_phase == PH_REQUEST) && req_low;
        frozen_now = req_frozen || (fall && bus_phase == PH_REQUEST && req_low);

        if (!it.io_cycle_n && (bus_phase == PH_ADDRESS || bus_phase == PH_DATA)) begin
            // The CPU took the bus back: drop everything and request again later.
            release_lines();
            req_frozen = 1'b0;
            gap_left = cfg_gap;
            bus_phase = PH_REQUEST;
            n_aborts++;
        end else begin
            case (bus_phase)
                PH_REQUEST: begin
                    if (drv_req_n && gap_left == 0) drv_req_n = 1'b0;
                    if (!it.mem_cycle_n && !it.grant_in_n && !drv_req_n && frozen_now &&
                        it.io_cycle_n) begin
                        drv_req_n  = 1'b1;
                        drv_bus_n  = ~xfer_address;
                        drv_astb_n = 1'b0;
                        drv_dir_n  = !xfer_is_write;
                        addr_hold  = 2'd2;
                        bus_phase  = PH_ADDRESS;
                    end
                end
                PH_ADDRESS: begin
                    if (addr_hold != 0) begin
                        addr_hold--;
                    end else begin
                        drv_astb_n = 1'b1;
                        drv_dir_n  = 1'b1;
                        drv_bus_n  = xfer_is_write ?
                            ~{{(dbms_pkg::BUS_W - dbms_pkg::WORD_W){1'b0}}, xfer_wdata} :
                            dbms_pkg::BUS_RELEASED;
                        drv_dstb_n = 1'b0;
                        rd_latched = 1'b0;
                        bus_phase  = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (!xfer_is_write && it.bus_data_n != dbms_pkg::BUS_RELEASED) begin
                        rd_latch   = ~it.bus_data_n[dbms_pkg::WORD_W-1:0];
                        rd_latched = 1'b1;
                    end
                    if (!it.ready_n) begin
                        if (!xfer_is_write)
                            ack_word = rd_latched ? rd_latch :
                                                    ~it.bus_data_n[dbms_pkg::WORD_W-1:0];
                        drv_dstb_n = 1'b1;
                        drv_bus_n  = dbms_pkg::BUS_RELEASED;
                        drv_dir_n  = 1'b1;
                        bus_phase  = PH_END;
                    end
                end
                PH_END: begin
                    if (it.ready_n) begin
                        ack_pend   = 1'b1;
                        ack_is_err = 1'b0;
                        gap_left   = cfg_gap;
                        bus_phase  = PH_IDLE;
                        n_acked++;
                    end
                end
                default: begin
                end
            endcase

            if (bus_phase != PH_IDLE) begin
                busy_ticks = busy_ticks + 1'b1;
                if (busy_ticks >= cfg_limit) begin
                    release_lines();
                    ack_pend   = 1'b1;
                    ack_is_err = 1'b1;
                    ack_word   = '0;
                    gap_left   = cfg_gap;
                    bus_phase  = PH_IDLE;
                    n_timeouts++;
                end
            end else begin
                busy_ticks = '0;
            end
        end
        last_mem_n = it.mem_cycle_n;

        r.ack_valid     = ack_pend;
        r.ack_read_data = ack_pend ? ack_word : '0;
        r.ack_error     = ack_pend && ack_is_err;
        if (it.ack_taken) ack_pend = 1'b0;

        if (it.start_request && bus_phase == PH_IDLE && !ack_pend) begin
            xfer_is_write = it.start_is_write;
            xfer_address  = it.start_address;
            xfer_wdata    = it.start_write_data;
            busy_ticks    = '0;
            bus_phase     = PH_REQUEST;
            r.start_accepted = 1'b1;
            n_started++;
        end

        r.request_n        = drv_req_n;
        r.address_strobe_n = drv_astb_n;
        r.data_strobe_n    = drv_dstb_n;
        r.direction_n      = drv_dir_n;
        r.bus_drive_n      = drv_bus_n;
        r.busy_res         = (bus_phase != PH_IDLE) || ack_pend;
    endtask

    // Random bus clock, shaped by where the master currently is so that most
    // transfers get through claim, address, data and end.
    function automatic dbms_pkg::t_item next_bus_clock();
        dbms_pkg::t_item it;
        logic [95:0]     noise;
        int unsigned     pick;
        pick = $urandom_range(0, 9);
        it.start_address = (pick == 0) ? '0 : (pick == 1) ? dbms_pkg::BUS_RELEASED :
                                                           dbms_pkg::BUS_W'($urandom);
        it.start_request = (bus_phase == PH_IDLE && !ack_pend) ? ($urandom_range(0, 9) < 7)
                                                              : ($urandom_range(0, 9) < 2);
        it.start_is_write   = 1'($urandom_range(0, 1));
        it.start_write_data = dbms_pkg::WORD_W'($urandom);
        it.ack_taken = ack_pend ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 99) < 35) mem_line = !mem_line;
        it.mem_cycle_n = mem_line;
        it.grant_in_n = (bus_phase == PH_REQUEST) ? ($urandom_range(0, 9) < 3)
                                                  : 1'($urandom_range(0, 1));
        it.io_cycle_n = ($urandom_range(0, 99) >= 4);
        if (bus_phase == PH_DATA) it.ready_n = ($urandom_range(0, 99) >= 35);
        else if (bus_phase == PH_END) it.ready_n = ($urandom_range(0, 99) < 70);
        else it.ready_n = 1'($urandom_range(0, 1));
        it.bus_data_n = ($urandom_range(0, 99) < ((bus_phase == PH_DATA) ? 40 : 20)) ?
                        dbms_pkg::BUS_W'($urandom) : dbms_pkg::BUS_RELEASED;
        if ($urandom_range(0, 99) < 12) begin
            noise = {$urandom, $urandom, $urandom};
            it = noise[$bits(dbms_pkg::t_item)-1:0];
        end
        return it;
    endfunction

    task automatic send_item(input dbms_pkg::t_item it, input bit typed,
                             input dbms_pkg::t_result typed_res);
        dbms_pkg::t_result predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_start_request    <= it.start_request;
        i_start_address    <= it.start_address;
        i_start_is_write   <= it.start_is_write;
        i_start_write_data <= it.start_write_data;
        i_ack_taken        <= it.ack_taken;
        i_mem_cycle_n      <= it.mem_cycle_n;
        i_grant_in_n       <= it.grant_in_n;
        i_io_cycle_n       <= it.io_cycle_n;
        i_ready_n          <= it.ready_n;
        i_bus_data_n       <= it.bus_data_n;
        do @(posedge i_clk); while (o_stall);
        step_bus_master(it, predicted);
        bus_results_due.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (bus_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [dbms_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dbms_pkg::LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == dbms_pkg::CFG_RECOVERY_GAP) cfg_gap = value[dbms_pkg::GAP_W-1:0];
        else if (idx == dbms_pkg::CFG_TIMEOUT_LIMIT) cfg_limit = value;
    endtask

    // Registers change only with nothing in flight; the spare indexes must be ignored.
    task automatic apply_settings(input int unsigned gap, input int unsigned limit);
        drain_results();
        write_register(dbms_pkg::CFG_RECOVERY_GAP, dbms_pkg::LIMIT_W'(gap));
        write_register(dbms_pkg::CFG_TIMEOUT_LIMIT, dbms_pkg::LIMIT_W'(limit));
        write_register(CFG_SPARE_LO, dbms_pkg::LIMIT_W'($urandom));
        write_register(CFG_SPARE_HI, dbms_pkg::LIMIT_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idle_mode(input int unsigned mode);
        send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 59 : 0;
        recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 13 : 0;
    endtask

    task automatic check_field(input string name, input logic [dbms_pkg::BUS_W-1:0] want,
                               input logic [dbms_pkg::BUS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) i_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge i_clk) begin
        dbms_pkg::t_result got;
        dbms_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_request_n, o_address_strobe_n, o_data_strobe_n, o_direction_n,
                    o_bus_drive_n, o_start_accepted, o_ack_valid, o_ack_read_data,
                    o_ack_error, o_busy_res, o_collision};
            if (bus_results_due.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
            end else begin
                want = bus_results_due.pop_front();
                n_checked++;
                check_field("request_n", want.request_n, got.request_n);
                check_field("address_strobe_n", want.address_strobe_n, got.address_strobe_n);
                check_field("data_strobe_n", want.data_strobe_n, got.data_strobe_n);
                check_field("direction_n", want.direction_n, got.direction_n);
                check_field("bus_drive_n", want.bus_drive_n, got.bus_drive_n);
                check_field("start_accepted", want.start_accepted, got.start_accepted);
                check_field("ack_valid", want.ack_valid, got.ack_valid);
                check_field("ack_read_data", want.ack_read_data, got.ack_read_data);
                check_field("ack_error", want.ack_error, got.ack_error);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("collision", want.collision, got.collision);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dma_bus_master_sequencer_top: mismatch");
            $finish;
        end
    end

    initial begin
        dbms_pkg::t_item it;
        // Columns: start, address, write, write data, ack taken,
        //          mem_n, grant_n, io_n, ready_n, bus_n.
        // A read of the top address that latches its word early, then a write
        // that is aborted by an I/O cycle in the address phase and retried.
        script[0]  = '{bus_item(0, 0, 0, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 1,
                       RESULT_AT_REST};
        script[1]  = '{bus_item(0, 0, 0, 0, 1, 0, 0, 0, 0, 24'h00_0000), 1, RESULT_AT_REST};
        script[2]  = '{bus_item(1, 24'hFF_FFFF, 0, 16'hFFFF, 0, 1, 1, 1, 1,
                                dbms_pkg::BUS_RELEASED), 0, '0};
        script[3]  = '{bus_item(1, 0, 1, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[4]  = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[5]  = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[6]  = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[7]  = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[8]  = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, 24'h00_0000), 0, '0};
        script[9]  = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 0, dbms_pkg::BUS_RELEASED), 0, '0};
        script[10] = '{bus_item(0, 0, 0, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[11] = '{bus_item(1, 0, 1, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[12] = '{bus_item(1, 0, 1, 0, 1, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[13] = '{bus_item(0, 0, 0, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[14] = '{bus_item(0, 0, 0, 0, 0, 0, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[15] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[16] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 0, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[17] = '{bus_item(0, 0, 0, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[18] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[19] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[20] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[21] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[22] = '{bus_item(0, 0, 0, 0, 0, 0, 0, 1, 0, dbms_pkg::BUS_RELEASED), 0, '0};
        script[23] = '{bus_item(0, 0, 0, 0, 0, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};
        script[24] = '{bus_item(0, 0, 0, 0, 1, 1, 1, 1, 1, dbms_pkg::BUS_RELEASED), 0, '0};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idle_mode(0);
        apply_settings(1, dbms_pkg::LIMIT_RESET);
        for (int k = 0; k < SCRIPT_LEN; k++)
            send_item(script[k].stim, script[k].typed, script[k].res);

        for (int s = 0; s < N_SETTINGS; s++) begin
            set_idle_mode(mode_plan[s]);
            apply_settings(gap_plan[s], limit_plan[s]);
            for (int n = 0; n < count_plan[s]; n++) begin
                it = next_bus_clock();
                send_item(it, 1'b0, '0);
                // Now and then hold the sender until every result is back.
                if (n % 200 == 199) drain_results();
            end
        end

        drain_results();
        $display("%0d bus clocks checked over %0d register settings and three idle patterns",
                 n_checked, N_SETTINGS + 1);
        $display("%0d transfers taken: %0d completed, %0d timed out, %0d I/O aborts",
                 n_started, n_acked, n_timeouts, n_aborts);
        $display("%0d I/O cycles overlapped a held grant", n_collisions);
        if (mismatches == 0)
            $display("dma_bus_master_sequencer_top: match");
        else
            $display("dma_bus_master_sequencer_top: mismatch");
        $finish;
    end

endmodule
